FILE: design/pdabpc_pkg.sv
`timescale 1ns / 1ps

package pdabpc_pkg;

    typedef enum logic [1:0] {
        MODE_MEM     = 2'd0,
        MODE_PORT_RD = 2'd1,
        MODE_PORT_WR = 2'd2,
        MODE_UART    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        TGT_FLASH  = 3'd0,
        TGT_RAM    = 3'd1,
        TGT_SCREEN = 3'd2,
        TGT_CLOCK  = 3'd3,
        TGT_UART   = 3'd4,
        TGT_NONE   = 3'd5
    } tgt_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_RAM    = 2'd1,
        KIND_SCREEN = 2'd2,
        KIND_FLASH  = 2'd3
    } kind_t;

    // 16 kb windows, selected by address bits 15..14
    localparam logic [1:0] WIN_FIXED  = 2'd0;
    localparam logic [1:0] WIN_ROM    = 2'd1;
    localparam logic [1:0] WIN_BANKED = 2'd2;
    localparam logic [1:0] WIN_RAM    = 2'd3;

    localparam logic [7:0] PORT_KEYS    = 8'h01;
    localparam logic [7:0] PORT_IRQ     = 8'h03;
    localparam logic [7:0] PORT_ID      = 8'h04;
    localparam logic [7:0] PORT_ROM_LO  = 8'h05;
    localparam logic [7:0] PORT_ROM_HI  = 8'h06;
    localparam logic [7:0] PORT_RAM_LO  = 8'h07;
    localparam logic [7:0] PORT_RAM_HI  = 8'h08;
    localparam logic [7:0] PORT_ADC     = 8'h09;
    localparam logic [7:0] PORT_SPEAKER = 8'h28;
    localparam logic [7:0] PORT_ZERO    = 8'h2D;

    // clock chip 0x10-0x1f, uart 0x30-0x37
    localparam logic [3:0] CLOCK_HI = 4'h1;
    localparam logic [4:0] UART_HI  = 5'b00110;

    // ram high codes that load the banked window
    localparam logic [7:0] CODE_SCREEN = 8'h06;
    localparam logic [7:0] CODE_RAM    = 8'h01;
    localparam logic [7:0] CODE_FLASH1 = 8'h03;
    localparam logic [7:0] CODE_FLASH0 = 8'h07;

    // rom high codes that pick the flash chip
    localparam logic [7:0] ROM_CHIP1 = 8'h03;
    localparam logic [7:0] ROM_CHIP2 = 8'h05;

    localparam logic [7:0] RD_ID       = 8'h7F;
    localparam logic [7:0] RD_UNMAPPED = 8'hFF;
    localparam logic [7:0] IRQ_UART    = 8'h08;
    localparam int         SPK_BIT     = 3;

    typedef struct packed {
        logic        uart_level;
        logic [2:0]  key_row_c;
        logic [2:0]  key_row_b;
        logic [2:0]  key_row_a;
        logic [7:0]  write_data;
        logic [15:0] address;
        mode_t       mode;
    } item_t;

    typedef struct packed {
        logic [7:0] key_select;
        logic [7:0] pending_irq;
        logic [5:0] rom_bank_low;
        logic [7:0] rom_bank_high;
        logic [5:0] ram_bank_low;
        logic [7:0] ram_bank_high;
        logic [7:0] adc_status;
        logic [7:0] speaker_reg;
        kind_t      window_kind;
        logic [1:0] window_chip;
        logic [5:0] window_bank;
    } state_t;

    localparam state_t ST_RESET = '{
        key_select:    8'h00,
        pending_irq:   8'h00,
        rom_bank_low:  6'h00,
        rom_bank_high: 8'h00,
        ram_bank_low:  6'h00,
        ram_bank_high: 8'h00,
        adc_status:    8'h00,
        speaker_reg:   8'h00,
        window_kind:   KIND_NONE,
        window_chip:   2'd0,
        window_bank:   6'h00
    };

    typedef struct packed {
        tgt_t        target;
        logic [1:0]  chip;
        logic [19:0] phys_offset;
        logic [7:0]  read_data;
    } acc_t;

    typedef struct packed {
        logic        speaker_out;
        logic        irq_out;
        logic [7:0]  read_data;
        logic [19:0] phys_offset;
        logic [1:0]  chip;
        tgt_t        target;
    } res_t;

endpackage

FILE: design/pdabpc_state.sv
`timescale 1ns / 1ps

module pdabpc_state
    import pdabpc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   step,
    input  item_t  item,
    output state_t st,
    output logic   irq_next,
    output logic   spk_next
);

    state_t     st_reg;
    state_t     st_next;
    logic [7:0] port;

    assign port = item.address[7:0];

    always_comb
    begin
        st_next = st_reg;
        if (step)
        begin
            unique case (item.mode)
                MODE_PORT_WR:
                begin
                    unique case (port)
                        PORT_KEYS:    st_next.key_select = item.write_data;
                        PORT_IRQ:     st_next.pending_irq = st_reg.pending_irq & ~item.write_data;
                        PORT_ROM_LO:  st_next.rom_bank_low = item.write_data[5:0];
                        PORT_ROM_HI:  st_next.rom_bank_high = item.write_data;
                        PORT_RAM_LO:  st_next.ram_bank_low = item.write_data[5:0];
                        PORT_RAM_HI:  st_next.ram_bank_high = item.write_data;
                        PORT_ADC:     st_next.adc_status = item.write_data | 8'h01;
                        PORT_SPEAKER: st_next.speaker_reg = item.write_data;
                        default:      ;
                    endcase
                    // bank register writes reload the window on a known code
                    if (port == PORT_ROM_LO || port == PORT_ROM_HI ||
                        port == PORT_RAM_LO || port == PORT_RAM_HI)
                    begin
                        unique case (st_next.ram_bank_high)
                            CODE_SCREEN:
                            begin
                                st_next.window_kind = KIND_SCREEN;
                                st_next.window_bank = st_next.ram_bank_low;
                            end
                            CODE_RAM:
                            begin
                                st_next.window_kind = KIND_RAM;
                                st_next.window_bank = st_next.ram_bank_low;
                            end
                            CODE_FLASH1:
                            begin
                                st_next.window_kind = KIND_FLASH;
                                st_next.window_chip = 2'd1;
                                st_next.window_bank = st_next.ram_bank_low;
                            end
                            CODE_FLASH0:
                            begin
                                st_next.window_kind = KIND_FLASH;
                                st_next.window_chip = 2'd0;
                                st_next.window_bank = st_next.ram_bank_low;
                            end
                            default: ;
                        endcase
                    end
                end
                MODE_UART:
                begin
                    st_next.pending_irq = (st_reg.pending_irq & ~IRQ_UART) |
                                          (item.uart_level ? IRQ_UART : 8'h00);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    assign st       = st_reg;
    assign irq_next = |st_next.pending_irq;
    assign spk_next = st_next.speaker_reg[SPK_BIT];

endmodule

FILE: design/pdabpc_map.sv
`timescale 1ns / 1ps

module pdabpc_map
    import pdabpc_pkg::*;
(
    input  item_t  item,
    input  state_t st,
    output acc_t   acc
);

    logic [7:0]  port;
    logic [13:0] low;
    logic [2:0]  keys;

    assign port = item.address[7:0];
    assign low  = item.address[13:0];

    always_comb
    begin
        keys = 3'b111;
        if (st.key_select[0]) keys = keys & item.key_row_a;
        if (st.key_select[1]) keys = keys & item.key_row_b;
        if (st.key_select[2]) keys = keys & item.key_row_c;
    end

    always_comb
    begin
        acc.target      = TGT_NONE;
        acc.chip        = 2'd0;
        acc.phys_offset = 20'd0;
        acc.read_data   = 8'h00;
        unique case (item.mode)
            MODE_MEM:
            begin
                unique case (item.address[15:14])
                    WIN_FIXED:
                    begin
                        acc.target      = TGT_FLASH;
                        acc.phys_offset = {6'd0, low};
                    end
                    WIN_ROM:
                    begin
                        acc.target      = TGT_FLASH;
                        acc.phys_offset = {st.rom_bank_low, low};
                        if (st.rom_bank_high == ROM_CHIP1)
                            acc.chip = 2'd1;
                        else if (st.rom_bank_high == ROM_CHIP2)
                            acc.chip = 2'd2;
                    end
                    WIN_BANKED:
                    begin
                        unique case (st.window_kind)
                            KIND_RAM:
                            begin
                                acc.target      = TGT_RAM;
                                acc.phys_offset = {3'd0, st.window_bank[2:0], low};
                            end
                            KIND_SCREEN:
                            begin
                                acc.target      = TGT_SCREEN;
                                acc.phys_offset = {6'd0, low};
                            end
                            KIND_FLASH:
                            begin
                                acc.target      = TGT_FLASH;
                                acc.chip        = st.window_chip;
                                acc.phys_offset = {st.ram_bank_low, low};
                            end
                            KIND_NONE: ;
                        endcase
                    end
                    WIN_RAM:
                    begin
                        acc.target      = TGT_RAM;
                        acc.phys_offset = {6'd0, low};
                    end
                endcase
            end
            MODE_PORT_RD, MODE_PORT_WR:
            begin
                acc.phys_offset = {12'd0, port};
                if (port[7:4] == CLOCK_HI)
                begin
                    acc.target      = TGT_CLOCK;
                    acc.phys_offset = {16'd0, port[3:0]};
                end
                else if (port[7:3] == UART_HI)
                begin
                    acc.target      = TGT_UART;
                    acc.phys_offset = {17'd0, port[2:0]};
                end
                else if (item.mode == MODE_PORT_RD)
                begin
                    unique case (port)
                        PORT_KEYS:   acc.read_data = {5'b00001, keys};
                        PORT_IRQ:    acc.read_data = st.pending_irq;
                        PORT_ID:     acc.read_data = RD_ID;
                        PORT_ROM_LO: acc.read_data = {2'b00, st.rom_bank_low};
                        PORT_ROM_HI: acc.read_data = st.rom_bank_high;
                        PORT_RAM_LO: acc.read_data = {2'b00, st.ram_bank_low};
                        PORT_RAM_HI: acc.read_data = st.ram_bank_high;
                        PORT_ADC:    acc.read_data = st.adc_status;
                        PORT_ZERO:   acc.read_data = 8'h00;
                        default:     acc.read_data = RD_UNMAPPED;
                    endcase
                end
            end
            MODE_UART: ;
        endcase
    end

endmodule

FILE: design/pda_bank_and_port_controller.sv
`timescale 1ns / 1ps

// system controller: memory window decode and internal ports
// input channel s_*: one bus event per item, its kind in s_tuser
//   (memory decode, port read, port write, uart interrupt level)
// output channel m_*: one result item per input item, in order
// an accepted item sits in the input register, then passes the window decode,
//   port logic and state update into the result register
// throughput: one item per cycle while m_tready is high, both registers moving together
// the bank, key, interrupt, adc and speaker registers update as an item
//   enters the result register; irq_out and speaker_out show them after it
// reset clears the state and valid registers, the banked window reads as
//   unmapped, both channels empty
// when m_tready is low the result holds, one more item waits in the input
//   register, and s_tready drops until the result is taken
module pda_bank_and_port_controller
    import pdabpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address, write_data, key_row_a, key_row_b,
                                   // key_row_c, uart_level
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // target, chip, phys_offset, read_data,
                                   // irq_out, speaker_out
);

    item_t  in_reg;
    logic   in_valid_reg;
    res_t   res_reg;
    res_t   res_next;
    logic   out_valid_reg;
    logic   out_load;
    logic   in_take;
    item_t  in_item;
    state_t st;
    acc_t   acc;
    logic   irq_next;
    logic   spk_next;

    assign in_item = '{
        uart_level: s_tdata[33],
        key_row_c:  s_tdata[32:30],
        key_row_b:  s_tdata[29:27],
        key_row_a:  s_tdata[26:24],
        write_data: s_tdata[23:16],
        address:    s_tdata[15:0],
        mode:       mode_t'(s_tuser)
    };

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_take  = s_tvalid && s_tready;

    pdabpc_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (out_load),
        .item     (in_reg),
        .st       (st),
        .irq_next (irq_next),
        .spk_next (spk_next)
    );

    pdabpc_map u_map (
        .item (in_reg),
        .st   (st),
        .acc  (acc)
    );

    always_comb
    begin
        res_next.target      = acc.target;
        res_next.chip        = acc.chip;
        res_next.phys_offset = acc.phys_offset;
        res_next.read_data   = acc.read_data;
        res_next.irq_out     = irq_next;
        res_next.speaker_out = spk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= in_item;
        if (out_load)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_reg};

    a_irq_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.irq_out == (st.pending_irq != 8'h00)))
        else $error("irq_out disagrees with pending interrupts");

    a_spk_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.speaker_out == st.speaker_reg[SPK_BIT]))
        else $error("speaker_out disagrees with speaker register");

    a_rd_internal_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.target != TGT_NONE) |-> (res_reg.read_data == 8'h00))
        else $error("read data on an external target");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

import pdabpc_pkg::*;

class bus_event_board;
    state_t regs = ST_RESET;
    res_t   awaited_results[$];
    int     faults = 0;
    int     checked = 0;
    int     seen[4] = '{0, 0, 0, 0};

    function void log_fault(string msg);
        faults++;
        if (faults <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function int count();
        return awaited_results.size();
    endfunction

    // works out the result of one bus event and moves the register copy on
    function res_t decode_bus_event(item_t it);
        res_t       r;
        logic [7:0] port;
        logic [13:0] low;
        logic [2:0] keys;
        port = it.address[7:0];
        low = it.address[13:0];
        r.target = TGT_NONE;
        r.chip = 2'd0;
        r.phys_offset = 20'd0;
        r.read_data = 8'd0;
        case (it.mode)
            MODE_MEM:
            begin
                r.phys_offset = {6'd0, low};
                case (it.address[15:14])
                    WIN_FIXED: r.target = TGT_FLASH;
                    WIN_ROM:
                    begin
                        r.target = TGT_FLASH;
                        if (regs.rom_bank_high == ROM_CHIP1)
                            r.chip = 2'd1;
                        else if (regs.rom_bank_high == ROM_CHIP2)
                            r.chip = 2'd2;
                        r.phys_offset = {regs.rom_bank_low, low};
                    end
                    WIN_BANKED:
                    begin
                        case (regs.window_kind)
                            KIND_RAM:
                            begin
                                r.target = TGT_RAM;
                                r.phys_offset = {3'd0, regs.window_bank[2:0], low};
                            end
                            KIND_SCREEN: r.target = TGT_SCREEN;
                            KIND_FLASH:
                            begin
                                r.target = TGT_FLASH;
                                r.chip = regs.window_chip;
                                r.phys_offset = {regs.ram_bank_low, low};
                            end
                            default:
                            begin
                                r.target = TGT_NONE;
                                r.phys_offset = 20'd0;
                            end
                        endcase
                    end
                    default: r.target = TGT_RAM;
                endcase
            end
            MODE_PORT_RD, MODE_PORT_WR:
            begin
                r.phys_offset = {12'd0, port};
                if (port[7:4] == CLOCK_HI)
                begin
                    r.target = TGT_CLOCK;
                    r.phys_offset = {16'd0, port[3:0]};
                end
                else if (port[7:3] == UART_HI)
                begin
                    r.target = TGT_UART;
                    r.phys_offset = {17'd0, port[2:0]};
                end
                else if (it.mode == MODE_PORT_RD)
                begin
                    case (port)
                        PORT_KEYS:
                        begin
                            keys = 3'b111;
                            if (regs.key_select[0])
                                keys = keys & it.key_row_a;
                            if (regs.key_select[1])
                                keys = keys & it.key_row_b;
                            if (regs.key_select[2])
                                keys = keys & it.key_row_c;
                            r.read_data = {5'b00001, keys};
                        end
                        PORT_IRQ:    r.read_data = regs.pending_irq;
                        PORT_ID:     r.read_data = RD_ID;
                        PORT_ROM_LO: r.read_data = {2'b00, regs.rom_bank_low};
                        PORT_ROM_HI: r.read_data = regs.rom_bank_high;
                        PORT_RAM_LO: r.read_data = {2'b00, regs.ram_bank_low};
                        PORT_RAM_HI: r.read_data = regs.ram_bank_high;
                        PORT_ADC:    r.read_data = regs.adc_status;
                        PORT_ZERO:   r.read_data = 8'h00;
                        default:     r.read_data = RD_UNMAPPED;
                    endcase
                end
                else
                begin
                    case (port)
                        PORT_KEYS:    regs.key_select = it.write_data;
                        PORT_IRQ:     regs.pending_irq = regs.pending_irq & ~it.write_data;
                        PORT_ROM_LO:  regs.rom_bank_low = it.write_data[5:0];
                        PORT_ROM_HI:  regs.rom_bank_high = it.write_data;
                        PORT_RAM_LO:  regs.ram_bank_low = it.write_data[5:0];
                        PORT_RAM_HI:  regs.ram_bank_high = it.write_data;
                        PORT_ADC:     regs.adc_status = it.write_data | 8'h01;
                        PORT_SPEAKER: regs.speaker_reg = it.write_data;
                        default:      ;
                    endcase
                    // bank writes reload the banked window, unknown codes keep it
                    if (port == PORT_ROM_LO || port == PORT_ROM_HI ||
                        port == PORT_RAM_LO || port == PORT_RAM_HI)
                    begin
                        case (regs.ram_bank_high)
                            CODE_SCREEN:
                            begin
                                regs.window_kind = KIND_SCREEN;
                                regs.window_bank = regs.ram_bank_low;
                            end
                            CODE_RAM:
                            begin
                                regs.window_kind = KIND_RAM;
                                regs.window_bank = regs.ram_bank_low;
                            end
                            CODE_FLASH1:
                            begin
                                regs.window_kind = KIND_FLASH;
                                regs.window_chip = 2'd1;
                                regs.window_bank = regs.ram_bank_low;
                            end
                            CODE_FLASH0:
                            begin
                                regs.window_kind = KIND_FLASH;
                                regs.window_chip = 2'd0;
                                regs.window_bank = regs.ram_bank_low;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default:
                regs.pending_irq = (regs.pending_irq & ~IRQ_UART) |
                                   (it.uart_level ? IRQ_UART : 8'h00);
        endcase
        r.irq_out = |regs.pending_irq;
        r.speaker_out = regs.speaker_reg[SPK_BIT];
        return r;
    endfunction

    function void note_event(item_t it);
        seen[it.mode]++;
        awaited_results.push_back(decode_bus_event(it));
    endfunction

    function void check_result(res_t got);
        res_t want;
        if (awaited_results.size() == 0)
        begin
            log_fault($sformatf("result with nothing awaited: %h", got));
            return;
        end
        want = awaited_results.pop_front();
        checked++;
        if (got.target !== want.target || got.chip !== want.chip ||
            got.phys_offset !== want.phys_offset || got.read_data !== want.read_data ||
            got.irq_out !== want.irq_out || got.speaker_out !== want.speaker_out)
            log_fault({
                $sformatf("result %0d exp tgt %0d chip %0d off %h rd %h irq %b spk %b",
                          checked, want.target, want.chip, want.phys_offset,
                          want.read_data, want.irq_out, want.speaker_out),
                $sformatf(", got tgt %0d chip %0d off %h rd %h irq %b spk %b",
                          got.target, got.chip, got.phys_offset, got.read_data,
                          got.irq_out, got.speaker_out)});
    endfunction
endclass

module testbench;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    bus_event_board tracker;
    bit no_idle;
    int stall_left = 0;
    int sent = 0;
    int waited;

    pda_bank_and_port_controller DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_result(res_t'(m_tdata[34:0]));
            if (s_tvalid && s_tready)
                tracker.note_event(item_t'({s_tdata[33:0], s_tuser}));
        end
    end

    function automatic item_t mk(mode_t m, logic [15:0] a, logic [7:0] d, logic lvl);
        item_t it;
        it.mode = m;
        it.address = a;
        it.write_data = d;
        it.key_row_a = 3'($urandom_range(0, 7));
        it.key_row_b = 3'($urandom_range(0, 7));
        it.key_row_c = 3'($urandom_range(0, 7));
        it.uart_level = lvl;
        return it;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        it = mk(MODE_MEM, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 99);
        if (pick < 30)
            it.mode = MODE_MEM;
        else if (pick < 52)
        begin
            it.mode = MODE_PORT_WR;
            it.address[7:0] = PORT_ROM_LO + 8'($urandom_range(0, 3));
            if (it.address[7:0] == PORT_RAM_HI && $urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 3))
                    0: it.write_data = CODE_SCREEN;
                    1: it.write_data = CODE_RAM;
                    2: it.write_data = CODE_FLASH1;
                    default: it.write_data = CODE_FLASH0;
                endcase
            end
            else if (it.address[7:0] == PORT_ROM_HI && $urandom_range(0, 1))
                it.write_data = $urandom_range(0, 1) ? ROM_CHIP1 : ROM_CHIP2;
        end
        else if (pick < 67)
        begin
            it.mode = MODE_PORT_RD;
            case ($urandom_range(0, 11))
                0: it.address[7:0] = PORT_KEYS;
                1: it.address[7:0] = PORT_IRQ;
                2: it.address[7:0] = PORT_ID;
                3: it.address[7:0] = PORT_ROM_LO;
                4: it.address[7:0] = PORT_ROM_HI;
                5: it.address[7:0] = PORT_RAM_LO;
                6: it.address[7:0] = PORT_RAM_HI;
                7: it.address[7:0] = PORT_ADC;
                8: it.address[7:0] = PORT_ZERO;
                9: it.address[7:4] = CLOCK_HI;
                10: it.address[7:3] = UART_HI;
                default: ;
            endcase
        end
        else if (pick < 77)
        begin
            it.mode = MODE_PORT_WR;
            case ($urandom_range(0, 6))
                0: it.address[7:0] = PORT_KEYS;
                1: it.address[7:0] = PORT_IRQ;
                2: it.address[7:0] = PORT_ADC;
                3: it.address[7:0] = PORT_SPEAKER;
                4: it.address[7:4] = CLOCK_HI;
                5: it.address[7:3] = UART_HI;
                default: ;
            endcase
        end
        else if (pick < 87)
            it.mode = MODE_UART;
        else
            it.mode = mode_t'($urandom_range(0, 3));
        return it;
    endfunction

    task automatic send_item(item_t it);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, it.uart_level, it.key_row_c, it.key_row_b, it.key_row_a,
                    it.write_data, it.address};
        s_tuser <= it.mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.count() != 0);
    endtask

    initial
    begin
        tracker = new;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 40'd0;
        s_tuser = MODE_MEM;
        m_tready = 1'b0;
        no_idle = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(mk(MODE_MEM, 16'h0000, 8'h00, 1'b0));
        send_item(mk(MODE_MEM, 16'hBFFF, 8'h00, 1'b0));
        send_item(mk(MODE_MEM, 16'hFFFF, 8'hFF, 1'b1));
        send_item(mk(MODE_PORT_RD, {8'hFF, PORT_ID}, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_RD, 16'h00FF, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_RD, {8'h00, PORT_ZERO}, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_RD, 16'h001F, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_WR, 16'h0030, 8'hFF, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_HI}, 8'hAA, 1'b0));
        send_item(mk(MODE_MEM, 16'h8000, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_LO}, 8'hFF, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_HI}, CODE_RAM, 1'b0));
        send_item(mk(MODE_MEM, 16'hBFFF, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_HI}, CODE_SCREEN, 1'b0));
        send_item(mk(MODE_MEM, 16'h8123, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_HI}, CODE_FLASH1, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_LO}, 8'h15, 1'b0));
        send_item(mk(MODE_MEM, 16'h9ABC, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_RAM_HI}, CODE_FLASH0, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_ROM_HI}, ROM_CHIP2, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_ROM_LO}, 8'hFF, 1'b0));
        send_item(mk(MODE_MEM, 16'h7FFF, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_KEYS}, 8'h07, 1'b0));
        send_item(mk(MODE_PORT_RD, {8'h00, PORT_KEYS}, 8'h00, 1'b0));
        send_item(mk(MODE_UART, 16'h0000, 8'h00, 1'b1));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_IRQ}, 8'hFF, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_SPEAKER}, 8'h08, 1'b0));
        send_item(mk(MODE_PORT_WR, {8'h00, PORT_ADC}, 8'h00, 1'b0));
        send_item(mk(MODE_PORT_RD, {8'h00, PORT_ADC}, 8'h00, 1'b0));
        drain_results();

        for (int i = 0; i < 1850; i++)
        begin
            if (i % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (i == 900)
                drain_results();
            if (i >= 1650)
                no_idle = 1'b1;
            send_item(rand_item());
        end
        s_tvalid <= 1'b0;

        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (tracker.count() != 0 && waited < 5000);
        repeat (4) @(posedge clk);
        if (tracker.count() != 0)
            tracker.log_fault($sformatf("%0d results never arrived", tracker.count()));

        $display("sent %0d items: %0d decodes, %0d port reads, %0d port writes, %0d uart",
                 sent, tracker.seen[MODE_MEM], tracker.seen[MODE_PORT_RD],
                 tracker.seen[MODE_PORT_WR], tracker.seen[MODE_UART]);
        $display("checked %0d results, %0d faults", tracker.checked, tracker.faults);
        if (tracker.faults == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
